// ===== design/spoken_number_segment_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// spoken number segment sequencer: assertion macros
// shared property shapes, clocked on clk_i and quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SPOKEN_NUMBER_SEGMENT_SEQUENCER_UNIT_DEFINES_SVH
`define SPOKEN_NUMBER_SEGMENT_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define SNSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SNSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/snss_pkg.sv =====
// ----------------------------------------------------------------------------
// snss_pkg
// types, constants and the control store of the spoken number sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package snss_pkg;

  localparam int unsigned SnssBinW    = 20;
  localparam int unsigned SnssDigits  = 6;
  localparam int unsigned BcdW        = 4 * SnssDigits;
  localparam int unsigned CntDigits   = 4;   // count is spoken mod 10000
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned SegW        = 8;
  localparam int unsigned StepW       = 5;

  localparam logic [SnssBinW-1:0] TotalMax = 20'd999999;
  localparam logic [SegW-1:0]     TensBase = 8'd19;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHundred    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHundredAnd = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgThousand   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgThousandAnd = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgPiece      = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgPieces     = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgTotal      = 8'd6;
  localparam logic [CfgIdxW-1:0] CfgTotalEn    = 8'd7;

  typedef struct packed {
    logic [15:0] piece_count;
    logic [19:0] running_total;
    logic        voice_fault;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segment_number;
    logic       last_segment;
  } out_item_t;

  typedef struct packed {
    logic [SegW-1:0] hundred;
    logic [SegW-1:0] hundred_and;
    logic [SegW-1:0] thousand;
    logic [SegW-1:0] thousand_and;
    logic [SegW-1:0] piece;
    logic [SegW-1:0] pieces;
    logic [SegW-1:0] total;
    logic            total_en;
  } cfg_t;

  // item status handed to the sequencer
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic tot_skip;
  } flags_t;

  // one segment offered by the sequencer
  typedef struct packed {
    logic            vld;
    logic [SegW-1:0] seg;
  } emit_t;

  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_D5,
    SRC_D2,
    SRC_PA_FIRST,
    SRC_PA_SECOND,
    SRC_PB_FIRST,
    SRC_PB_SECOND,
    SRC_HUND,
    SRC_HUND_AND,
    SRC_THOU,
    SRC_THOU_AND,
    SRC_PIECE,
    SRC_TOTAL
  } src_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_HI_ZERO,
    COND_D5_ZERO,
    COND_D2_ZERO,
    COND_PA_ZERO,
    COND_PB_ZERO,
    COND_PA_ONE_SEG,
    COND_PB_ONE_SEG,
    COND_CNT_ZERO,
    COND_SEL_TOTAL,
    COND_TOT_SKIP
  } cond_e;

  typedef logic [StepW-1:0] step_t;

  // control word: condition true jumps silently, false emits the source segment, if any, and moves on
  typedef struct packed {
    src_e  src;
    cond_e cond;
    step_t t_true;
    step_t t_false;
    logic  set_total;
  } uword_t;

  localparam step_t LStart   = 5'd0;
  localparam step_t LNum     = 5'd1;
  localparam step_t LD5      = 5'd2;
  localparam step_t LHa      = 5'd3;
  localparam step_t LHw1     = 5'd4;
  localparam step_t LPa1     = 5'd5;
  localparam step_t LPa2     = 5'd6;
  localparam step_t LMid     = 5'd7;
  localparam step_t LMid2    = 5'd8;
  localparam step_t LThEnd   = 5'd9;
  localparam step_t LLow     = 5'd10;
  localparam step_t LHb      = 5'd11;
  localparam step_t LHb2     = 5'd12;
  localparam step_t LHw2     = 5'd13;
  localparam step_t LPb1     = 5'd14;
  localparam step_t LPb2     = 5'd15;
  localparam step_t LRet     = 5'd16;
  localparam step_t LPiece   = 5'd17;
  localparam step_t LTot     = 5'd18;
  localparam step_t LDone    = 5'd19;

  function automatic uword_t snss_rom(step_t a);
    uword_t w;
    w = '{src: SRC_NONE, cond: COND_NEVER, t_true: LDone, t_false: LDone, set_total: 1'b0};
    case (a)
      LStart: w = '{src: SRC_NONE, cond: COND_CNT_ZERO, t_true: LTot, t_false: LNum,
                    set_total: 1'b0};
      LNum:   w = '{src: SRC_NONE, cond: COND_HI_ZERO, t_true: LLow, t_false: LD5,
                    set_total: 1'b0};
      LD5:    w = '{src: SRC_D5, cond: COND_D5_ZERO, t_true: LPa1, t_false: LHa,
                    set_total: 1'b0};
      LHa:    w = '{src: SRC_HUND_AND, cond: COND_PA_ZERO, t_true: LHw1, t_false: LPa1,
                    set_total: 1'b0};
      LHw1:   w = '{src: SRC_HUND, cond: COND_NEVER, t_true: LMid, t_false: LMid,
                    set_total: 1'b0};
      LPa1:   w = '{src: SRC_PA_FIRST, cond: COND_NEVER, t_true: LPa2, t_false: LPa2,
                    set_total: 1'b0};
      LPa2:   w = '{src: SRC_PA_SECOND, cond: COND_PA_ONE_SEG, t_true: LMid, t_false: LMid,
                    set_total: 1'b0};
      LMid:   w = '{src: SRC_THOU, cond: COND_D2_ZERO, t_true: LMid2, t_false: LHb,
                    set_total: 1'b0};
      LMid2:  w = '{src: SRC_THOU_AND, cond: COND_PB_ZERO, t_true: LThEnd, t_false: LPb1,
                    set_total: 1'b0};
      LThEnd: w = '{src: SRC_THOU, cond: COND_NEVER, t_true: LRet, t_false: LRet,
                    set_total: 1'b0};
      LLow:   w = '{src: SRC_NONE, cond: COND_D2_ZERO, t_true: LPb1, t_false: LHb,
                    set_total: 1'b0};
      LHb:    w = '{src: SRC_D2, cond: COND_NEVER, t_true: LHb2, t_false: LHb2,
                    set_total: 1'b0};
      LHb2:   w = '{src: SRC_HUND_AND, cond: COND_PB_ZERO, t_true: LHw2, t_false: LPb1,
                    set_total: 1'b0};
      LHw2:   w = '{src: SRC_HUND, cond: COND_NEVER, t_true: LRet, t_false: LRet,
                    set_total: 1'b0};
      LPb1:   w = '{src: SRC_PB_FIRST, cond: COND_NEVER, t_true: LPb2, t_false: LPb2,
                    set_total: 1'b0};
      LPb2:   w = '{src: SRC_PB_SECOND, cond: COND_PB_ONE_SEG, t_true: LRet, t_false: LRet,
                    set_total: 1'b0};
      LRet:   w = '{src: SRC_NONE, cond: COND_SEL_TOTAL, t_true: LDone, t_false: LPiece,
                    set_total: 1'b0};
      LPiece: w = '{src: SRC_PIECE, cond: COND_NEVER, t_true: LTot, t_false: LTot,
                    set_total: 1'b0};
      LTot:   w = '{src: SRC_TOTAL, cond: COND_TOT_SKIP, t_true: LDone, t_false: LNum,
                    set_total: 1'b1};
      default: w = '{src: SRC_NONE, cond: COND_NEVER, t_true: LDone, t_false: LDone,
                     set_total: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/snss_bcd.sv =====
// ----------------------------------------------------------------------------
// snss_bcd
// shift-and-add-3 binary to decimal converter, one input bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module snss_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [snss_pkg::SnssBinW-1:0] bin_i,
  output logic                          busy_o,
  output logic [snss_pkg::BcdW-1:0]     bcd_o
);
  import snss_pkg::*;

  localparam int unsigned CntW = $clog2(SnssBinW);

  logic [SnssBinW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d, adj;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;

  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < SnssDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[SnssBinW-1]};
      bin_d = {bin_q[SnssBinW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(SnssBinW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

// ===== design/snss_seq.sv =====
// ----------------------------------------------------------------------------
// snss_seq
// microprogrammed word sequencer: one control word per step picks a segment
// ----------------------------------------------------------------------------
`default_nettype none

module snss_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      run_i,
  input  logic                      adv_i,
  input  logic [snss_pkg::BcdW-1:0] cnt_bcd_i,
  input  logic [snss_pkg::BcdW-1:0] tot_bcd_i,
  input  snss_pkg::cfg_t            cfg_i,
  input  snss_pkg::flags_t          flags_i,
  output snss_pkg::emit_t           emit_o,
  output logic                      done_o
);
  import snss_pkg::*;

  step_t           step_q, step_d;
  logic            sel_q, sel_d;
  uword_t          uw;
  logic [3:0]      dig [SnssDigits];
  logic            cond;
  logic [SegW-1:0] seg;
  logic            done;

  function automatic logic [SegW-1:0] digit_seg(logic [3:0] d);
    return {4'd0, d} + 8'd1;
  endfunction

  // 0..19 as one segment, otherwise the tens word
  function automatic logic [SegW-1:0] pair_first(logic [3:0] t, logic [3:0] o);
    logic [SegW-1:0] r;
    if (t < 4'd2) begin
      r = (t[0] ? 8'd10 : 8'd0) + {4'd0, o} + 8'd1;
    end else begin
      r = {4'd0, t} + TensBase;
    end
    return r;
  endfunction

  // digit view: count keeps its low four digits only
  always_comb begin
    for (int i = 0; i < SnssDigits; i++) begin
      if (sel_q) begin
        dig[i] = tot_bcd_i[4*i +: 4];
      end else if (i < CntDigits) begin
        dig[i] = cnt_bcd_i[4*i +: 4];
      end else begin
        dig[i] = 4'd0;
      end
    end
  end

  assign uw   = snss_rom(step_q);
  assign done = (step_q == LDone);

  always_comb begin
    case (uw.cond)
      COND_NEVER:      cond = 1'b0;
      COND_HI_ZERO:    cond = (dig[3] == 4'd0) && (dig[4] == 4'd0) && (dig[5] == 4'd0);
      COND_D5_ZERO:    cond = (dig[5] == 4'd0);
      COND_D2_ZERO:    cond = (dig[2] == 4'd0);
      COND_PA_ZERO:    cond = (dig[4] == 4'd0) && (dig[3] == 4'd0);
      COND_PB_ZERO:    cond = (dig[1] == 4'd0) && (dig[0] == 4'd0);
      COND_PA_ONE_SEG: cond = (dig[4] < 4'd2) || (dig[3] == 4'd0);
      COND_PB_ONE_SEG: cond = (dig[1] < 4'd2) || (dig[0] == 4'd0);
      COND_CNT_ZERO:   cond = flags_i.cnt_zero;
      COND_SEL_TOTAL:  cond = sel_q;
      COND_TOT_SKIP:   cond = flags_i.tot_skip;
      default:         cond = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.src)
      SRC_D5:        seg = digit_seg(dig[5]);
      SRC_D2:        seg = digit_seg(dig[2]);
      SRC_PA_FIRST:  seg = pair_first(dig[4], dig[3]);
      SRC_PA_SECOND: seg = digit_seg(dig[3]);
      SRC_PB_FIRST:  seg = pair_first(dig[1], dig[0]);
      SRC_PB_SECOND: seg = digit_seg(dig[0]);
      SRC_HUND:      seg = cfg_i.hundred;
      SRC_HUND_AND:  seg = cfg_i.hundred_and;
      SRC_THOU:      seg = cfg_i.thousand;
      SRC_THOU_AND:  seg = cfg_i.thousand_and;
      SRC_PIECE:     seg = flags_i.cnt_one ? cfg_i.piece : cfg_i.pieces;
      SRC_TOTAL:     seg = cfg_i.total;
      default:       seg = '0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    sel_d  = sel_q;
    if (start_i) begin
      step_d = LStart;
      sel_d  = 1'b0;
    end else if (run_i && adv_i && !done) begin
      step_d = cond ? uw.t_true : uw.t_false;
      if (uw.set_total) begin
        sel_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= LStart;
      sel_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      sel_q  <= sel_d;
    end
  end

  assign emit_o.vld = run_i && !done && !cond && (uw.src != SRC_NONE);
  assign emit_o.seg = seg;
  assign done_o     = done;

endmodule

`default_nettype wire

// ===== design/spoken_number_segment_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// spoken_number_segment_sequencer_unit
// turns a piece count and a running total into ordered voice segment numbers
// ----------------------------------------------------------------------------
// usage
//   in channel: one transfer is one announcement (count, total, fault flag)
//   out channel: one transfer per segment, last_segment set on the final one
//   cfg channel: always ready, index picks a word register, others ignored
// timing
//   after an input transfer the decimal converters shift in all 20 bits and
//   control moves on once both are done; the microprogram then runs 2 to 24
//   steps at one per cycle while not stalled, plus the end step and the flush
//   state; a faulted item is taken but starts nothing and gives no segments;
//   one item is in work at a time; in_ready returns after the final segment
//   has moved into the output register, which may still wait
// stalls
//   a one-deep pending register feeds the output register; with both full
//   and the receiver holding off, the next emitting step waits until it drains
// reset
//   all word registers clear to zero, control returns to idle, no output
// ----------------------------------------------------------------------------
`default_nettype none

`include "spoken_number_segment_sequencer_unit_defines.svh"

module spoken_number_segment_sequencer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  snss_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output snss_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [snss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [snss_pkg::SegW-1:0]    cfg_data_i
);
  import snss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  cfg_t            cfg_q, cfg_d;

  // item status, captured on the input transfer
  logic            cnt_zero_q, cnt_one_q, tot_zero_q;
  logic [SnssBinW-1:0] tot_sat;

  // pending segment and output register
  logic            pend_q, pend_d;
  logic [SegW-1:0] pend_seg_q, pend_seg_d;
  logic            out_vld_q, out_vld_d;
  out_item_t       out_q, out_d;
  logic            out_load;

  logic            accept, start, adv;
  logic            cnt_busy, tot_busy;
  logic [BcdW-1:0] cnt_bcd, tot_bcd;
  flags_t          flags;
  emit_t           emit;
  logic            seq_done;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // totals above the spoken range are clipped
  assign tot_sat = (in_data_i.running_total > TotalMax) ? TotalMax : in_data_i.running_total;

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHundred:     cfg_d.hundred      = cfg_data_i;
        CfgHundredAnd:  cfg_d.hundred_and  = cfg_data_i;
        CfgThousand:    cfg_d.thousand     = cfg_data_i;
        CfgThousandAnd: cfg_d.thousand_and = cfg_data_i;
        CfgPiece:       cfg_d.piece        = cfg_data_i;
        CfgPieces:      cfg_d.pieces       = cfg_data_i;
        CfgTotal:       cfg_d.total        = cfg_data_i;
        CfgTotalEn:     cfg_d.total_en     = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_zero_q <= (in_data_i.piece_count == 16'd0);
      cnt_one_q  <= (in_data_i.piece_count == 16'd1);
      tot_zero_q <= (tot_sat == '0);
    end
  end

  assign flags.cnt_zero = cnt_zero_q;
  assign flags.cnt_one  = cnt_one_q;
  assign flags.tot_skip = !cfg_q.total_en || tot_zero_q;

  // decimal digits of count and total, converted side by side
  snss_bcd u_cnt_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .bin_i   ({{(SnssBinW - 16){1'b0}}, in_data_i.piece_count}),
    .busy_o  (cnt_busy),
    .bcd_o   (cnt_bcd)
  );

  snss_bcd u_tot_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .bin_i   (tot_sat),
    .busy_o  (tot_busy),
    .bcd_o   (tot_bcd)
  );

  snss_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .run_i     (state_q == ST_RUN),
    .adv_i     (adv),
    .cnt_bcd_i (cnt_bcd),
    .tot_bcd_i (tot_bcd),
    .cfg_i     (cfg_q),
    .flags_i   (flags),
    .emit_o    (emit),
    .done_o    (seq_done)
  );

  // control: the pending register holds one segment back so the final one
  // can be tagged once the microprogram reaches its end
  always_comb begin
    state_d    = state_q;
    start      = 1'b0;
    adv        = 1'b1;
    out_load   = 1'b0;
    out_d      = out_q;
    pend_d     = pend_q;
    pend_seg_d = pend_seg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !in_data_i.voice_fault) begin
          start   = 1'b1;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!cnt_busy && !tot_busy) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        adv = !(emit.vld && pend_q && out_vld_q && !out_ready_i);
        if (seq_done) begin
          state_d = ST_FLUSH;
        end else if (emit.vld && adv) begin
          if (pend_q) begin
            out_load             = 1'b1;
            out_d.segment_number = pend_seg_q;
            out_d.last_segment   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_seg_d = emit.seg;
        end
      end
      ST_FLUSH: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (!out_vld_q || out_ready_i) begin
          out_load             = 1'b1;
          out_d.segment_number = pend_seg_q;
          out_d.last_segment   = 1'b1;
          pend_d               = 1'b0;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_seg_q <= pend_seg_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // pending segment is always handed on before the next item
  `SNSS_ASSERT_IMPL(a_idle_no_pend, state_q == ST_IDLE, !pend_q, "pending segment left in idle")
  // the microprogram only reads finished digits
  `SNSS_ASSERT_IMPL(a_run_conv_done, state_q == ST_RUN, !cnt_busy && !tot_busy,
    "digits read while converting")
  // the output register is never overwritten while it still waits
  `SNSS_ASSERT_IMPL(a_no_overrun, out_load, !out_vld_q || out_ready_i, "output register overrun")
  // a started item goes straight into conversion
  `SNSS_ASSERT_NEXT(a_start_conv, start, (state_q == ST_CONV) && cnt_busy && tot_busy,
    "conversion did not start")

endmodule

`default_nettype wire
